[rtl/core/dcpa_pkg.sv]
// Shared types and constants for the direct color pixel to ARGB converter.
// No dependencies.
package dcpa_pkg;

    localparam int unsigned NUM_CH = 4;
    localparam int unsigned CH_B = 0;
    localparam int unsigned CH_G = 1;
    localparam int unsigned CH_R = 2;
    localparam int unsigned CH_A = 3;
    localparam int unsigned DIV_STAGES = 8;
    localparam logic [7:0] CHAN_MAX = 8'hFF;

    typedef enum logic [2:0] {
        REG_RED_MASK    = 3'd0,
        REG_RED_SS      = 3'd1,
        REG_GREEN_MASK  = 3'd2,
        REG_GREEN_SS    = 3'd3,
        REG_BLUE_MASK   = 3'd4,
        REG_BLUE_SS     = 3'd5,
        REG_ALPHA_MASK  = 3'd6,
        REG_ALPHA_SS    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [NUM_CH-1:0][31:0] mask;
        logic [NUM_CH-1:0][4:0]  shift;
        logic [NUM_CH-1:0][31:0] scale;
    } t_cfg;

    // Channel order in arrays: blue, green, red, alpha (lowest index first)
    localparam t_cfg CFG_RESET = '{
        mask:  {32'hFF00_0000, 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF},
        shift: {5'd24, 5'd16, 5'd8, 5'd0},
        scale: {32'd255, 32'd255, 32'd255, 32'd255}
    };

    typedef struct packed {
        logic [NUM_CH-1:0][31:0] fld;
        logic [15:0]             x;
        logic [15:0]             y;
    } t_item;

endpackage

[rtl/core/direct_color_pixel_to_argb.sv]
// Top level of the direct color pixel to ARGB8888 converter.
// Depends on dcpa_pkg, dcpa_front, dcpa_queue, dcpa_back.
//
// Usage:
//   Input stream s_axis: tdata = pixel_word, dest_x, dest_y (from bit 0 up).
//   Output stream m_axis: tdata = argb_color, out_x, out_y (from bit 0 up).
//   Config channel: i_cfg_valid/o_cfg_ready with i_cfg_index (register
//   number 0..7) and i_cfg_data; o_cfg_ready is always high. Write only
//   while no pixel is in flight.
//   One pixel per clock sustained while m_axis_tready is high. On the way
//   to output valid the front register takes the transfer, then queue,
//   scale stage, eight quotient bit stages (the last is the output register).
//   Reset loads the standard 8:8:8:8 ARGB layout with full scale 255 and
//   empties all stages. When the receiver stalls, the divider pipeline
//   fills, then the four-entry queue and the front register, then
//   s_axis_tready drops.
module direct_color_pixel_to_argb (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // pixel_word[31:0], dest_x[47:32], dest_y[63:48]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // argb_color[31:0], out_x[47:32], out_y[63:48]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [36:0] i_cfg_data
);

    dcpa_pkg::t_cfg  r_cfg;
    dcpa_pkg::t_item front_item;
    dcpa_pkg::t_item queue_item;
    logic            front_valid;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    logic            q_push;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= dcpa_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (dcpa_pkg::t_reg_idx'(i_cfg_index))
                dcpa_pkg::REG_RED_MASK:   r_cfg.mask[dcpa_pkg::CH_R] <= i_cfg_data[31:0];
                dcpa_pkg::REG_GREEN_MASK: r_cfg.mask[dcpa_pkg::CH_G] <= i_cfg_data[31:0];
                dcpa_pkg::REG_BLUE_MASK:  r_cfg.mask[dcpa_pkg::CH_B] <= i_cfg_data[31:0];
                dcpa_pkg::REG_ALPHA_MASK: r_cfg.mask[dcpa_pkg::CH_A] <= i_cfg_data[31:0];
                dcpa_pkg::REG_RED_SS: begin
                    r_cfg.shift[dcpa_pkg::CH_R] <= i_cfg_data[4:0];
                    r_cfg.scale[dcpa_pkg::CH_R] <= i_cfg_data[36:5];
                end
                dcpa_pkg::REG_GREEN_SS: begin
                    r_cfg.shift[dcpa_pkg::CH_G] <= i_cfg_data[4:0];
                    r_cfg.scale[dcpa_pkg::CH_G] <= i_cfg_data[36:5];
                end
                dcpa_pkg::REG_BLUE_SS: begin
                    r_cfg.shift[dcpa_pkg::CH_B] <= i_cfg_data[4:0];
                    r_cfg.scale[dcpa_pkg::CH_B] <= i_cfg_data[36:5];
                end
                dcpa_pkg::REG_ALPHA_SS: begin
                    r_cfg.shift[dcpa_pkg::CH_A] <= i_cfg_data[4:0];
                    r_cfg.scale[dcpa_pkg::CH_A] <= i_cfg_data[36:5];
                end
                default: ;
            endcase
        end
    end

    dcpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pixel (s_axis_tdata[31:0]),
        .i_x     (s_axis_tdata[47:32]),
        .i_y     (s_axis_tdata[63:48]),
        .o_valid (front_valid),
        .i_full  (q_full),
        .o_item  (front_item)
    );

    assign q_push = front_valid && !q_full;

    dcpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (queue_item)
    );

    dcpa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .i_item  (queue_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_argb  (m_axis_tdata[31:0]),
        .o_x     (m_axis_tdata[47:32]),
        .o_y     (m_axis_tdata[63:48])
    );

endmodule

[rtl/core/dcpa_front.sv]
// Front end: takes input transfers, masks and shifts each channel field.
// Depends on dcpa_pkg.
module dcpa_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dcpa_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [31:0]          i_pixel,
    input  logic [15:0]          i_x,
    input  logic [15:0]          i_y,
    output logic                 o_valid,
    input  logic                 i_full,
    output dcpa_pkg::t_item      o_item
);

    logic            r_fv;
    dcpa_pkg::t_item r_item;
    dcpa_pkg::t_item n_item;

    always_comb begin
        for (int c = 0; c < dcpa_pkg::NUM_CH; c++) begin
            n_item.fld[c] = (i_pixel & i_cfg.mask[c]) >> i_cfg.shift[c];
        end
        n_item.x = i_x;
        n_item.y = i_y;
    end

    assign o_ready = !r_fv || !i_full;
    assign o_valid = r_fv;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (o_ready) begin
            r_fv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

[rtl/core/dcpa_queue.sv]
// Four-entry queue between the front and back ends.
// Depends on dcpa_pkg.
module dcpa_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dcpa_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output dcpa_pkg::t_item o_item
);

    dcpa_pkg::t_item r_mem [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;

    assign o_full  = r_cnt == 3'd4;
    assign o_empty = r_cnt == 3'd0;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (i_pop)  r_rp <= r_rp + 2'd1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 3'd1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("queue underflow");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("queue count out of range");

endmodule

[rtl/core/dcpa_back.sv]
// Back end: scale stage then one quotient bit per stage, output register last.
// Depends on dcpa_pkg.
module dcpa_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dcpa_pkg::t_cfg  i_cfg,
    input  logic            i_empty,
    output logic            o_pop,
    input  dcpa_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [31:0]     o_argb,
    output logic [15:0]     o_x,
    output logic [15:0]     o_y
);

    localparam int unsigned NS = dcpa_pkg::DIV_STAGES + 1;
    localparam int unsigned NC = dcpa_pkg::NUM_CH;

    logic [NS-1:0]               r_v;
    logic [NS-1:0][NC-1:0][39:0] r_rem;
    logic [NS-1:0][NC-1:0][7:0]  r_q;
    logic [NS-1:0][NC-1:0]       r_dn;
    logic [NS-1:0][15:0]         r_x;
    logic [NS-1:0][15:0]         r_y;
    logic [NS:0]                 adv;

    logic [NC-1:0][39:0] n_rem;
    logic [NC-1:0][7:0]  n_q;
    logic [NC-1:0]       n_dn;

    always_comb begin
        adv[NS] = i_ready;
        for (int s = NS - 1; s >= 0; s--) begin
            adv[s] = !r_v[s] || adv[s+1];
        end
    end

    assign o_pop = adv[0] && !i_empty;

    always_comb begin
        logic [39:0] num;
        for (int c = 0; c < NC; c++) begin
            num = {i_item.fld[c], 8'd0} - {8'd0, i_item.fld[c]};
            n_rem[c] = num;
            n_q[c]   = 8'd0;
            n_dn[c]  = 1'b0;
            if (c == dcpa_pkg::CH_A && i_cfg.mask[c] == 32'd0) begin
                n_q[c]  = dcpa_pkg::CHAN_MAX;
                n_dn[c] = 1'b1;
            end else if (i_cfg.scale[c] == 32'd0) begin
                n_q[c]  = (i_item.fld[c] > 32'd255) ? dcpa_pkg::CHAN_MAX
                                                    : i_item.fld[c][7:0];
                n_dn[c] = 1'b1;
            end else if (num >= {i_cfg.scale[c], 8'd0}) begin
                n_q[c]  = dcpa_pkg::CHAN_MAX;
                n_dn[c] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) r_v[0] <= !i_empty;
            for (int s = 1; s < NS; s++) begin
                if (adv[s]) r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [39:0] d;
        logic [39:0] rem;
        logic [7:0]  q;
        if (adv[0]) begin
            r_rem[0] <= n_rem;
            r_q[0]   <= n_q;
            r_dn[0]  <= n_dn;
            r_x[0]   <= i_item.x;
            r_y[0]   <= i_item.y;
        end
        for (int s = 1; s < NS; s++) begin
            if (adv[s]) begin
                r_x[s]  <= r_x[s-1];
                r_y[s]  <= r_y[s-1];
                r_dn[s] <= r_dn[s-1];
                for (int c = 0; c < NC; c++) begin
                    d   = {8'd0, i_cfg.scale[c]} << (NS - 1 - s);
                    rem = r_rem[s-1][c];
                    q   = r_q[s-1][c];
                    if (!r_dn[s-1][c] && rem >= d) begin
                        rem           = rem - d;
                        q[NS - 1 - s] = 1'b1;
                    end
                    r_rem[s][c] <= rem;
                    r_q[s][c]   <= q;
                end
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_argb  = r_q[NS-1];
    assign o_x     = r_x[NS-1];
    assign o_y     = r_y[NS-1];

    a_rem_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS-1] && !r_dn[NS-1][dcpa_pkg::CH_R] |->
        r_rem[NS-1][dcpa_pkg::CH_R] < {8'd0, i_cfg.scale[dcpa_pkg::CH_R]})
        else $error("red remainder not below scale");
    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_v[0]) else $error("popped item lost");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_argb) && $stable(o_x) && $stable(o_y))
        else $error("output changed while stalled");

endmodule
